>>> sv/hs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hs_pkg: shared types and constants of the hillshade block
// Register indexes, sequencer states and fixed arithmetic widths.
// ----------------------------------------------------------------------------
package hs_pkg;

   typedef enum logic [2:0] {
      REG_ROW_LENGTH   = 3'd0,
      REG_FRAME_ROWS   = 3'd1,
      REG_CELL_SIZE    = 3'd2,
      REG_Z_FACTOR     = 3'd3,
      REG_LIGHT_FLAT   = 3'd4,
      REG_LIGHT_EAST   = 3'd5,
      REG_LIGHT_NORTH  = 3'd6
   } csr_index_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_NORM = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_SQRT = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_OUT  = 6'b100000
   } back_state_type;

   localparam int NORM_BITS   = 24;  // magnitudes after normalization
   localparam int MUL_W       = 25;  // signed multiplier operand
   localparam int PROD_W      = 50;
   localparam int NACC_W      = 43;  // light dot product accumulator
   localparam int SQ_W        = 50;  // sum of squares
   localparam int RAD_W       = 64;
   localparam int ROOT_W      = 32;
   localparam int SREM_W      = 35;
   localparam int DIV_W       = 51;  // dividend / quotient
   localparam int DREM_W      = 34;
   localparam int QUEUE_DEPTH = 4;
   localparam logic [15:0] SHADE_MAX = 16'd65280;

endpackage

>>> sv/hs_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hs_channels: valid/ready channel interfaces of the hillshade block
// Sample input, shade result and register write channels.
// ----------------------------------------------------------------------------
interface hs_req_if #(parameter int ELEV_BITS = 20);
   logic                        valid;
   logic                        ready;
   logic signed [ELEV_BITS-1:0] elevation;
   logic                        frame_start;
   modport source(output valid, elevation, frame_start, input ready);
   modport sink(input valid, elevation, frame_start, output ready);
endinterface

interface hs_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] shade;
   logic        last_of_frame;
   modport source(output valid, shade, last_of_frame, input ready);
   modport sink(input valid, shade, last_of_frame, output ready);
endinterface

interface hs_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

>>> sv/hs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hs_front: raster scan, line stores and 3x3 window
// Tracks column and row, reads the line stores, forms Horn gradients and
// queues one entry per interior pixel.
// ----------------------------------------------------------------------------
module hs_front import hs_pkg::*; #(
   parameter int MAX_WIDTH = 4096,
   parameter int ELEV_BITS = 20
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [ELEV_BITS-1:0] elevation,
   input  logic                        frame_start,
   input  logic [12:0]                 row_length,
   input  logic [15:0]                 frame_rows,
   output logic                        push_valid,
   input  logic                        push_ready,
   output logic [2*(ELEV_BITS+3):0]    push_data
);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int GW = ELEV_BITS + 3;

   logic [WW-1:0] wd;
   logic [15:0]   ht;
   logic [CW-1:0] col_ff, col_in, c0, c1;
   logic [15:0]   row_ff, row_in, r0, r1, r2, r3;
   logic [WW-1:0] c3;
   logic          wrap1, end_row, interior, last;
   logic          accept, finish;

   logic                        busy_ff, int_ff, last_ff;
   logic [CW-1:0]               addr_ff;
   logic signed [ELEV_BITS-1:0] elev_ff, rd_up_ff, rd_mid_ff;
   logic signed [ELEV_BITS-1:0] win_ff [6];
   logic signed [ELEV_BITS-1:0] mem_upper_ff [MAX_WIDTH];
   logic signed [ELEV_BITS-1:0] mem_middle_ff [MAX_WIDTH];

   logic signed [GW-1:0] t_x, m_x, e_x, a_x, d_x, g_x, b_x, h_x, gx, gy;

   always_comb begin
      if (row_length < 13'd3) begin
         wd = WW'(3);
      end else if (32'(row_length) > MAX_WIDTH) begin
         wd = WW'(MAX_WIDTH);
      end else begin
         wd = WW'(row_length);
      end
      ht = (frame_rows < 16'd3) ? 16'd3 : frame_rows;

      c0 = frame_start ? '0 : col_ff;
      r0 = frame_start ? '0 : row_ff;
      wrap1 = WW'(c0) >= wd;
      c1 = wrap1 ? '0 : c0;
      r1 = wrap1 ? r0 + 16'd1 : r0;
      r2 = (r1 >= ht) ? '0 : r1;

      interior = (r2 >= 16'd2) && (c1 >= CW'(2));
      last     = (r2 == ht - 16'd1) && (WW'(c1) == wd - WW'(1));

      c3      = WW'(c1) + WW'(1);
      end_row = c3 >= wd;
      r3      = r2 + 16'd1;
      col_in  = end_row ? '0 : CW'(c3);
      row_in  = end_row ? ((r3 >= ht) ? '0 : r3) : r2;
   end

   assign req_ready  = !busy_ff;
   assign accept     = req_valid && !busy_ff;
   assign push_valid = busy_ff && int_ff;
   assign finish     = busy_ff && (!int_ff || push_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         col_ff  <= '0;
         row_ff  <= '0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
            col_ff  <= col_in;
            row_ff  <= row_in;
         end else if (finish) begin
            busy_ff   <= 1'b0;
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= rd_up_ff;
            win_ff[4] <= rd_mid_ff;
            win_ff[5] <= elev_ff;
         end
      end
   end

   // line stores: read on accept, write back when the pixel retires
   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff   <= c1;
         elev_ff   <= elevation;
         int_ff    <= interior;
         last_ff   <= last;
         rd_up_ff  <= mem_upper_ff[c1];
         rd_mid_ff <= mem_middle_ff[c1];
      end
      if (finish) begin
         mem_upper_ff[addr_ff]  <= rd_mid_ff;
         mem_middle_ff[addr_ff] <= elev_ff;
      end
   end

   assign t_x = GW'(rd_up_ff);
   assign m_x = GW'(rd_mid_ff);
   assign e_x = GW'(elev_ff);
   assign a_x = GW'(win_ff[0]);
   assign d_x = GW'(win_ff[1]);
   assign g_x = GW'(win_ff[2]);
   assign b_x = GW'(win_ff[3]);
   assign h_x = GW'(win_ff[5]);

   assign gx = (t_x + (m_x <<< 1) + e_x) - (a_x + (d_x <<< 1) + g_x);
   assign gy = (g_x + (h_x <<< 1) + e_x) - (a_x + (b_x <<< 1) + t_x);

   assign push_data = {last_ff, gx, gy};

endmodule

>>> sv/hs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hs_fifo: short queue between gradient front and shading back
// Register-based first-in first-out buffer.
// ----------------------------------------------------------------------------
module hs_fifo import hs_pkg::*; #(
   parameter int WIDTH = 47,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PW = $clog2(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, rd_ff;
   logic [PW:0]      count_ff;
   logic             do_push, do_pop;

   assign push_ready = count_ff != (PW+1)'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (PW+1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (PW+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> sv/hs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hs_back: shading sequencer
// Scales gradients, normalizes, forms the light dot product and the sum of
// squares on one shared multiplier, then square root and division bit by bit.
// ----------------------------------------------------------------------------
module hs_back import hs_pkg::*; #(
   parameter int ELEV_BITS = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  logic [2*(ELEV_BITS+3):0] pop_data,
   input  logic [7:0]               cell_size,
   input  logic [7:0]               z_factor,
   input  logic [14:0]              light_flat,
   input  logic signed [15:0]       light_east,
   input  logic signed [15:0]       light_north,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [15:0]              shade,
   output logic                     last_of_frame
);
   localparam int GW = ELEV_BITS + 3;
   localparam int VW = GW + 9;

   back_state_type state_ff;

   logic signed [GW-1:0] gx, gy;
   logic signed [VW-1:0] vp, wp;
   logic [7:0]           cs_eff;

   logic [VW-1:0] um_ff, vm_ff, wm_ff;
   logic          vneg_ff, wneg_ff, last_ff, zero_ff;
   logic          big;

   logic [2:0]               idx_ff;
   logic signed [MUL_W-1:0]  op_a, op_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [NACC_W-1:0] n_ff, term;
   logic [SQ_W-1:0]          sum_ff;

   logic [RAD_W-1:0]  rad_ff;
   logic [SREM_W-1:0] srem_ff, remx, trial;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [SREM_W-1:0] srem_in;

   logic [DIV_W-1:0]    dd_ff;
   logic [DREM_W-1:0]   drem_ff, dtry;
   logic [ROOT_W:0]     divisor;
   logic [5:0]          cnt_ff;

   logic rsp_valid_ff, out_free;
   logic [15:0] shade_ff;
   logic        out_last_ff;

   assign gy     = pop_data[GW-1:0];
   assign gx     = pop_data[2*GW-1:GW];
   assign cs_eff = (cell_size == 8'd0) ? 8'd1 : cell_size;
   assign vp     = $signed({1'b0, z_factor}) * gx;
   assign wp     = $signed({1'b0, z_factor}) * gy;

   assign pop_ready = state_ff == ST_IDLE;
   assign big = (64'(um_ff) >= (64'd1 << NORM_BITS)) ||
                (64'(vm_ff) >= (64'd1 << NORM_BITS)) ||
                (64'(wm_ff) >= (64'd1 << NORM_BITS));

   // shared multiplier operands
   always_comb begin
      case (idx_ff)
         3'd0: begin
            op_a = MUL_W'($signed({1'b0, light_flat}));
            op_b = MUL_W'($signed({1'b0, um_ff[NORM_BITS-1:0]}));
         end
         3'd1: begin
            op_a = MUL_W'(light_east);
            op_b = MUL_W'($signed({1'b0, vm_ff[NORM_BITS-1:0]}));
         end
         3'd2: begin
            op_a = MUL_W'(light_north);
            op_b = MUL_W'($signed({1'b0, wm_ff[NORM_BITS-1:0]}));
         end
         3'd3: begin
            op_a = MUL_W'($signed({1'b0, um_ff[NORM_BITS-1:0]}));
            op_b = op_a;
         end
         3'd4: begin
            op_a = MUL_W'($signed({1'b0, vm_ff[NORM_BITS-1:0]}));
            op_b = op_a;
         end
         3'd5: begin
            op_a = MUL_W'($signed({1'b0, wm_ff[NORM_BITS-1:0]}));
            op_b = op_a;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // signed contribution of the previous product to the dot product
   always_comb begin
      case (idx_ff)
         3'd1:    term = NACC_W'(prod_ff);
         3'd2:    term = vneg_ff ? NACC_W'(prod_ff) : -NACC_W'(prod_ff);
         3'd3:    term = wneg_ff ? -NACC_W'(prod_ff) : NACC_W'(prod_ff);
         default: term = '0;
      endcase
   end

   // square root step: two radicand bits per cycle
   always_comb begin
      remx  = {srem_ff[SREM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
      trial = {1'b0, root_ff, 2'b01};
      if (remx >= trial) begin
         srem_in = remx - trial;
         root_in = {root_ff[ROOT_W-2:0], 1'b1};
      end else begin
         srem_in = remx;
         root_in = {root_ff[ROOT_W-2:0], 1'b0};
      end
   end

   assign divisor = {root_ff, 1'b0};
   assign dtry    = {drem_ff[DREM_W-2:0], dd_ff[DIV_W-1]};
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop_valid) begin
                  state_ff <= ST_NORM;
               end
            end
            ST_NORM: begin
               if (!big) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (idx_ff == 3'd6) begin
                  state_ff <= (n_ff <= 0) ? ST_OUT : ST_SQRT;
               end
            end
            ST_SQRT: begin
               if (cnt_ff == 6'(ROOT_W - 1)) begin
                  state_ff <= (root_in == '0) ? ST_OUT : ST_DIV;
               end
            end
            ST_DIV: begin
               if (cnt_ff == 6'(DIV_W - 1)) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            um_ff   <= VW'({cs_eff, 3'b000});
            vm_ff   <= vp[VW-1] ? VW'(-vp) : VW'(vp);
            wm_ff   <= wp[VW-1] ? VW'(-wp) : VW'(wp);
            vneg_ff <= vp[VW-1];
            wneg_ff <= wp[VW-1];
            last_ff <= pop_data[2*GW];
         end
         ST_NORM: begin
            // truncate magnitudes one bit a cycle until all fit
            if (big) begin
               um_ff <= um_ff >> 1;
               vm_ff <= vm_ff >> 1;
               wm_ff <= wm_ff >> 1;
            end
            idx_ff <= 3'd0;
            n_ff   <= '0;
            sum_ff <= '0;
         end
         ST_MUL: begin
            prod_ff <= op_a * op_b;
            idx_ff  <= idx_ff + 3'd1;
            n_ff    <= n_ff + term;
            if (idx_ff >= 3'd4) begin
               sum_ff <= sum_ff + SQ_W'(prod_ff);
            end
            zero_ff <= 1'b1;
            rad_ff  <= {2'b00, sum_ff + ((idx_ff >= 3'd4) ? SQ_W'(prod_ff) : '0), 12'd0};
            srem_ff <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
         end
         ST_SQRT: begin
            srem_ff <= srem_in;
            root_ff <= root_in;
            rad_ff  <= rad_ff << 2;
            if (cnt_ff == 6'(ROOT_W - 1)) begin
               dd_ff   <= (DIV_W'(n_ff) << 8) - DIV_W'(n_ff);
               drem_ff <= '0;
               cnt_ff  <= '0;
               zero_ff <= root_in == '0;
            end else begin
               cnt_ff  <= cnt_ff + 6'd1;
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit a cycle
            if (dtry >= DREM_W'(divisor)) begin
               drem_ff <= dtry - DREM_W'(divisor);
               dd_ff   <= {dd_ff[DIV_W-2:0], 1'b1};
            end else begin
               drem_ff <= dtry;
               dd_ff   <= {dd_ff[DIV_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 6'd1;
         end
         ST_OUT: begin
            if (out_free) begin
               out_last_ff <= last_ff;
               if (zero_ff) begin
                  shade_ff <= '0;
               end else if (dd_ff > DIV_W'(SHADE_MAX)) begin
                  shade_ff <= SHADE_MAX;
               end else begin
                  shade_ff <= dd_ff[15:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign shade         = shade_ff;
   assign last_of_frame = out_last_ff;

endmodule

>>> sv/dem_hillshade_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dem_hillshade_3x3: streaming Horn hillshade over an elevation raster
// Register file, gradient front, queue and shading back.
// ----------------------------------------------------------------------------
// Samples enter in row order; in the front each sample has a line store
// read, then write back and window shift, and the front takes a new sample
// only once the last has retired. Every interior pixel queues its gradients
// for the shading back, which works on one pixel at a time: a pop, up to six
// normalizing shifts, the shared multiplier, square root, division and
// output; a pixel facing away from the light skips root and division. The
// back sets the sustained rate. Border pixels give no result in the back.
// The user must write registers only while the block is idle; the block
// does not enforce it. Index 0 is the image width, 1 the height, 2 the cell
// size, 3 the z factor and 4 to 6 the light vector.
module dem_hillshade_3x3 import hs_pkg::*; #(
   parameter int MAX_WIDTH = 4096,
   parameter int ELEV_BITS = 20
) (
   input  logic      clock,
   input  logic      reset,
   hs_req_if.sink    req_ch,
   hs_rsp_if.source  rsp_ch,
   hs_csr_if.sink    csr_ch
);
   localparam int QW = 2 * (ELEV_BITS + 3) + 1;

   logic [12:0]        row_length_ff;
   logic [15:0]        frame_rows_ff;
   logic [7:0]         cell_size_ff;
   logic [7:0]         z_factor_ff;
   logic [14:0]        light_flat_ff;
   logic signed [15:0] light_east_ff;
   logic signed [15:0] light_north_ff;

   logic          push_valid, push_ready, pop_valid, pop_ready;
   logic [QW-1:0] push_data, pop_data;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff   <= 13'd1024;
         frame_rows_ff   <= 16'd1024;
         cell_size_ff    <= 8'd5;
         z_factor_ff     <= 8'd1;
         light_flat_ff   <= 15'd23170;
         light_east_ff   <= -16'sd16384;
         light_north_ff  <= 16'sd16384;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            REG_ROW_LENGTH:   row_length_ff   <= csr_ch.data[12:0];
            REG_FRAME_ROWS:   frame_rows_ff   <= csr_ch.data;
            REG_CELL_SIZE:    cell_size_ff    <= csr_ch.data[7:0];
            REG_Z_FACTOR:     z_factor_ff     <= csr_ch.data[7:0];
            REG_LIGHT_FLAT:   light_flat_ff   <= csr_ch.data[14:0];
            REG_LIGHT_EAST:   light_east_ff   <= csr_ch.data;
            REG_LIGHT_NORTH:  light_north_ff  <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   hs_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .ELEV_BITS (ELEV_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_ch.valid),
      .req_ready    (req_ch.ready),
      .elevation    (req_ch.elevation),
      .frame_start  (req_ch.frame_start),
      .row_length   (row_length_ff),
      .frame_rows   (frame_rows_ff),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_data    (push_data)
   );

   hs_fifo #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   hs_back #(
      .ELEV_BITS (ELEV_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_data      (pop_data),
      .cell_size     (cell_size_ff),
      .z_factor      (z_factor_ff),
      .light_flat    (light_flat_ff),
      .light_east    (light_east_ff),
      .light_north   (light_north_ff),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .shade         (rsp_ch.shade),
      .last_of_frame (rsp_ch.last_of_frame)
   );

endmodule

>>> sv/hs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hs_checker: port-level checks of the hillshade block
// Result channel behavior over time, bound to the top level.
// ----------------------------------------------------------------------------
module hs_checker import hs_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_shade,
   input logic        rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_shade) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_shade_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_shade <= SHADE_MAX)
      else $error("shade above saturation limit");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

endmodule

bind dem_hillshade_3x3 hs_checker u_hs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_shade (rsp_ch.shade),
   .rsp_last  (rsp_ch.last_of_frame)
);

>>> tb/hs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hs_predictor: shade predictor and result compare for dem_hillshade_3x3
// Watches register writes and sample transfers, keeps its own line stores,
// window and counters, queues the expected shade of every interior pixel and
// compares each result transfer against the oldest expected shade.
// ----------------------------------------------------------------------------
module hs_predictor import hs_pkg::*; (
   input  logic clock,
   input  logic reset,
   hs_req_if    req_ch,
   hs_rsp_if    rsp_ch,
   hs_csr_if    csr_ch,
   output int   mismatches,
   output int   awaiting
);

   typedef struct {
      logic [15:0] shade;
      logic        last;
   } shade_result_type;

   shade_result_type shade_q[$];
   shade_result_type want;

   logic [12:0]        width_reg;
   logic [15:0]        height_reg;
   logic [7:0]         cell_reg;
   logic [7:0]         zf_reg;
   logic [14:0]        flat_reg;
   logic signed [15:0] east_reg;
   logic signed [15:0] north_reg;

   longint upper_line [4096];
   longint middle_line[4096];
   longint win[6];
   int     col;
   int     row;

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= x) r = t;
      end
      return r;
   endfunction

   function automatic longint shr_mag(longint x, int s);
      return (x < 0) ? -((-x) >>> s) : (x >>> s);
   endfunction

   function automatic logic [15:0] horn_shade(longint gx, longint gy);
      longint u, v, w, m, n;
      int s;
      longint unsigned sum, root, q;
      u = 8 * ((cell_reg == 0) ? 64'sd1 : longint'(cell_reg));
      v = longint'(zf_reg) * gx;
      w = longint'(zf_reg) * gy;
      m = u;
      if ((v < 0 ? -v : v) > m) m = (v < 0 ? -v : v);
      if ((w < 0 ? -w : w) > m) m = (w < 0 ? -w : w);
      s = 0;
      // normalize so the squares stay inside 64 bits
      while ((m >>> s) >= (64'sd1 <<< NORM_BITS)) s++;
      u = u >>> s;
      v = shr_mag(v, s);
      w = shr_mag(w, s);
      n = longint'(flat_reg) * u - longint'(east_reg) * v + longint'(north_reg) * w;
      if (n <= 0) return 16'd0;
      sum = u * u + v * v + w * w;
      root = int_sqrt(sum << 12);
      if (root == 0) return 16'd0;
      q = (longint'(n) * 255) / (root * 2);
      return (q > SHADE_MAX) ? SHADE_MAX : q[15:0];
   endfunction

   task automatic take_sample(input logic signed [19:0] e_in, input logic fs);
      int wd, ht;
      longint e, top, mid, gx, gy;
      shade_result_type res;
      wd = width_reg;
      if (wd < 3) wd = 3;
      if (wd > 4096) wd = 4096;
      ht = height_reg;
      if (ht < 3) ht = 3;
      e = e_in;
      if (fs) begin
         col = 0;
         row = 0;
      end
      if (col >= wd) begin
         col = 0;
         row++;
      end
      if (row >= ht) row = 0;
      top = upper_line[col];
      mid = middle_line[col];
      upper_line[col] = mid;
      middle_line[col] = e;
      if (row >= 2 && col >= 2) begin
         gx = (top + 2 * mid + e) - (win[0] + 2 * win[1] + win[2]);
         gy = (win[2] + 2 * win[5] + e) - (win[0] + 2 * win[3] + top);
         res.shade = horn_shade(gx, gy);
         res.last = (row == ht - 1 && col == wd - 1);
         shade_q.push_back(res);
      end
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = e;
      col++;
      if (col >= wd) begin
         col = 0;
         row++;
         if (row >= ht) row = 0;
      end
   endtask

   initial mismatches = 0;

   always @(posedge clock) begin
      if (reset) begin
         width_reg = 13'd1024;
         height_reg = 16'd1024;
         cell_reg = 8'd5;
         zf_reg = 8'd1;
         flat_reg = 15'd23170;
         east_reg = -16'sd16384;
         north_reg = 16'sd16384;
         for (int i = 0; i < 6; i++) win[i] = 0;
         col = 0;
         row = 0;
         shade_q.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_index_type'(csr_ch.index))
               REG_ROW_LENGTH:   width_reg = csr_ch.data[12:0];
               REG_FRAME_ROWS:   height_reg = csr_ch.data;
               REG_CELL_SIZE:    cell_reg = csr_ch.data[7:0];
               REG_Z_FACTOR:     zf_reg = csr_ch.data[7:0];
               REG_LIGHT_FLAT:   flat_reg = csr_ch.data[14:0];
               REG_LIGHT_EAST:   east_reg = csr_ch.data;
               REG_LIGHT_NORTH:  north_reg = csr_ch.data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            take_sample(req_ch.elevation, req_ch.frame_start);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (shade_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected shade transfer: got %0d last %0b",
                           rsp_ch.shade, rsp_ch.last_of_frame);
            end else begin
               want = shade_q.pop_front();
               if (rsp_ch.shade !== want.shade || rsp_ch.last_of_frame !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("shade mismatch: expected %0d last %0b, got %0d last %0b",
                              want.shade, want.last, rsp_ch.shade, rsp_ch.last_of_frame);
               end
            end
         end
      end
      awaiting <= shade_q.size();
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for dem_hillshade_3x3
// Programs the registers between phases, streams raster frames of varied
// shape and terrain with random gaps and result stalls, and reports whether
// the checker found mismatches.
// ----------------------------------------------------------------------------
module tb;
   import hs_pkg::*;

   logic clock;
   logic reset;
   int   mismatches;
   int   awaiting;
   int   sent;
   bit   hold_done;
   bit   burst;
   logic signed [19:0] terrain;

   hs_req_if #(.ELEV_BITS(20)) req_ch();
   hs_rsp_if rsp_ch();
   hs_csr_if csr_ch();

   dem_hillshade_3x3 #(.MAX_WIDTH(4096), .ELEV_BITS(20)) dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   hs_predictor chk (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch),
      .mismatches(mismatches), .awaiting(awaiting)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("Mismatches found");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 70) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [19:0] next_elev(int mode);
      case (mode)
         0: terrain = 20'($urandom);
         1: terrain = terrain + $signed(20'($urandom_range(0, 128)) - 20'sd64);
         2: terrain = $urandom_range(0, 1) ? 20'sh7FFFF : 20'sh80000;
         default: terrain = terrain + $signed(20'($urandom_range(0, 40000)) - 20'sd20000);
      endcase
      return terrain;
   endfunction

   task automatic send_sample(input logic signed [19:0] elev, input logic fs);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.elevation <= elev;
      req_ch.frame_start <= fs;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
   endtask

   task automatic send_run(input int n, input int mode, input bit seq_start);
      for (int i = 0; i < n; i++) send_sample(next_elev(mode), seq_start && i == 0);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] d);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= d;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   task automatic program_regs(input int w, h, cs, z, fl, ea, no);
      write_reg(REG_ROW_LENGTH, 16'(w));
      write_reg(REG_FRAME_ROWS, 16'(h));
      write_reg(REG_CELL_SIZE, 16'(cs));
      write_reg(REG_Z_FACTOR, 16'(z));
      write_reg(REG_LIGHT_FLAT, 16'(fl));
      write_reg(REG_LIGHT_EAST, 16'(ea));
      write_reg(REG_LIGHT_NORTH, 16'(no));
      csr_ch.valid <= 1'b0;
   endtask

   // drain all shades, then give border samples in the front time to retire
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
      repeat (200) @(posedge clock);
   endtask

   // result side: random stretches, plus one long hold-off to back up the input
   initial begin
      int r, len;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!hold_done && sent >= 250) begin
            hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (3000) @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
               rsp_ch.ready <= 1'b1;
               len = $urandom_range(50, 200);
            end else if (r < 60) begin
               rsp_ch.ready <= 1'b1;
               len = $urandom_range(1, 8);
            end else if (r < 95) begin
               rsp_ch.ready <= 1'b0;
               len = $urandom_range(1, 3);
            end else begin
               rsp_ch.ready <= 1'b0;
               len = $urandom_range(20, 80);
            end
            repeat (len) @(posedge clock);
         end
      end
   end

   initial begin
      int rnd_items, w, h, ew, eh, mode, nf, n;
      bit prev_whole;
      logic signed [19:0] pat[9];
      sent = 0;
      hold_done = 1'b0;
      burst = 1'b0;
      terrain = '0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.elevation <= '0;
      req_ch.frame_start <= 1'b0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= '0;
      csr_ch.data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // steepest cliff: lowest code on the left, highest on the right
      program_regs(3, 3, 5, 1, 23170, -16384, 16384);
      pat = '{20'sh80000, 20'sd0, 20'sh7FFFF, 20'sh80000, 20'sd0, 20'sh7FFFF,
              20'sh80000, 20'sd0, 20'sh7FFFF};
      for (int i = 0; i < 9; i++) send_sample(pat[i], i == 0);
      settle();

      // out-of-range width, height and cell size; long light vector saturates
      program_regs(0, 0, 0, 255, 32767, -32768, 32767);
      for (int i = 0; i < 9; i++) send_sample(20'(64 * (i % 3 + i / 3)), i == 0);
      // next frame without frame_start, facing away from the light
      for (int i = 0; i < 9; i++) send_sample(20'(-200000 * (i % 3)), 1'b0);
      settle();

      // widest raster clamps to the line store depth; first row gives no shade
      burst = 1'b1;
      program_regs(8191, 65535, 255, 255, $urandom_range(0, 32767), $urandom, $urandom);
      send_run(40, 1, 1'b1);
      burst = 1'b0;
      settle();

      // shrink width, then height, in the middle of a frame
      program_regs(8, 6, 3, 2, 20000, 10000, -12000);
      send_run(8 * 4 + 6, 1, 1'b1);
      settle();
      write_reg(REG_ROW_LENGTH, 16'd4);
      csr_ch.valid <= 1'b0;
      send_run(20, 3, 1'b0);
      settle();
      write_reg(REG_FRAME_ROWS, 16'd3);
      csr_ch.valid <= 1'b0;
      send_run(12, 1, 1'b0);
      settle();

      rnd_items = 0;
      while (rnd_items < 950) begin
         n = $urandom_range(0, 99);
         w = (n < 85) ? $urandom_range(3, 10) : (n < 90) ? $urandom_range(0, 2)
                                                        : $urandom_range(11, 40);
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
         ew = (w < 3) ? 3 : w;
         eh = (h < 3) ? 3 : h;
         program_regs(w, h, $urandom_range(0, 255),
                      ($urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 255)),
                      $urandom_range(0, 32767), $urandom, $urandom);
         mode = $urandom_range(0, 3);
         burst = ($urandom_range(0, 3) == 0);
         nf = $urandom_range(1, 3);
         prev_whole = 1'b0;
         for (int f = 0; f < nf; f++) begin
            n = ew * eh;
            // an aborted frame leaves the next one to restart by frame_start
            if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n - 1);
            send_run(n, mode, !prev_whole || $urandom_range(0, 1));
            prev_whole = (n == ew * eh);
            rnd_items += n;
         end
         burst = 1'b0;
         settle();
      end

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
      repeat (300) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> filelist.f
sv/hs_pkg.sv
sv/hs_channels.sv
sv/hs_front.sv
sv/hs_fifo.sv
sv/hs_back.sv
sv/dem_hillshade_3x3.sv
sv/hs_checker.sv
tb/hs_checker.sv
tb/tb.sv
